// ===== hw/rtl/bole_pkg.sv =====
package bole_pkg;

   localparam int DEPTH = 32;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 6;
   localparam int VAL_W = 32;
   localparam int ACT_W = 4;
   localparam int STAT_W = 3;
   // Wide enough to compare a position against the length plus one.
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [ACT_W-1:0] {
      ACT_INS_HEAD = 4'd0,
      ACT_INS_TAIL = 4'd1,
      ACT_INS_AT   = 4'd2,
      ACT_DEL_HEAD = 4'd3,
      ACT_DEL_TAIL = 4'd4,
      ACT_DEL_AT   = 4'd5,
      ACT_SEARCH   = 4'd6,
      ACT_SORT     = 4'd7,
      ACT_READ     = 4'd8
   } bole_action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_BEYOND   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FULL     = 3'd4,
      ST_NOTFOUND = 3'd5
   } bole_status_type;

   typedef struct packed {
      bole_action_type          action;
      logic signed [VAL_W-1:0]  item_value;
      logic [POS_W-1:0]         item_position;
   } bole_req_type;

   typedef struct packed {
      bole_status_type          status;
      logic [POS_W-1:0]         result_position;
      logic signed [VAL_W-1:0]  result_value;
      logic [POS_W-1:0]         list_length;
   } bole_res_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      logic [VAL_W-1:0]     data;
   } bole_wr_type;

endpackage

// ===== hw/rtl/bole_if.sv =====
interface bole_req_if import bole_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [ACT_W-1:0]         action;
   logic signed [VAL_W-1:0]  item_value;
   logic [POS_W-1:0]         item_position;

   modport source (output valid, output action, output item_value, output item_position,
                   input ready);
   modport sink (input valid, input action, input item_value, input item_position,
                 output ready);
endinterface

interface bole_rsp_if import bole_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic [POS_W-1:0]         result_position;
   logic signed [VAL_W-1:0]  result_value;
   logic [POS_W-1:0]         list_length;

   modport source (output valid, output status, output result_position,
                   output result_value, output list_length, input ready);
   modport sink (input valid, input status, input result_position,
                 input result_value, input list_length, output ready);
endinterface

// ===== hw/rtl/bole_ram.sv =====
module bole_ram #(
   parameter int DATA_W = 32,
   parameter int WORDS = 32,
   parameter int ADDR_BITS = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_W-1:0]    wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_W-1:0]    rd_data
);

   logic [DATA_W-1:0] mem [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bole_seq.sv =====
module bole_seq import bole_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bole_req_type        req_word,
   output logic                res_valid,
   input  logic                res_take,
   output bole_res_type        res_word,
   output bole_wr_type         mem_wr,
   output logic [ADDR_W-1:0]   mem_raddr,
   input  logic [VAL_W-1:0]    mem_rdata
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_SHIFT,
      S_INS_PUT,
      S_DEL_FIRST,
      S_DEL_SHIFT,
      S_READ_WAIT,
      S_SEARCH,
      S_SORT_LOAD,
      S_SORT_RUN,
      S_SORT_TAIL,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VAL_W-1:0]       val_ff, val_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;
   logic [ADDR_W-1:0]      k_ff, k_in;
   logic [ADDR_W-1:0]      last_ff, last_in;
   logic [VAL_W-1:0]       carry_ff, carry_in;
   bole_status_type        status_ff, status_in;
   logic [POS_W-1:0]       rpos_ff, rpos_in;
   logic [VAL_W-1:0]       rval_ff, rval_in;

   logic [CMP_W-1:0]       pos_x;
   logic [CMP_W-1:0]       cnt_x;
   logic                   full;
   logic                   empty;
   logic [ADDR_W-1:0]      last_idx;
   logic [ADDR_W-1:0]      ins_idx;
   logic [ADDR_W-1:0]      del_idx;
   logic [ADDR_W-1:0]      k_up;
   logic [ADDR_W-1:0]      k_down;
   logic [POS_W-1:0]       k_pos;

   assign pos_x    = CMP_W'(req_word.item_position);
   assign cnt_x    = CMP_W'(cnt_ff);
   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign last_idx = ADDR_W'(cnt_ff - CNT_W'(1));
   assign k_up     = ADDR_W'(k_ff + ADDR_W'(1));
   assign k_down   = ADDR_W'(k_ff - ADDR_W'(1));
   assign k_pos    = POS_W'(CMP_W'(k_ff) + CMP_W'(1));

   always_comb begin
      case (req_word.action)
         ACT_INS_HEAD: ins_idx = '0;
         ACT_INS_TAIL: ins_idx = ADDR_W'(cnt_ff);
         default:      ins_idx = ADDR_W'(pos_x - CMP_W'(1));
      endcase
      case (req_word.action)
         ACT_DEL_HEAD: del_idx = '0;
         ACT_DEL_TAIL: del_idx = last_idx;
         default:      del_idx = ADDR_W'(pos_x - CMP_W'(1));
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      val_in    = val_ff;
      idx_in    = idx_ff;
      k_in      = k_ff;
      last_in   = last_ff;
      carry_in  = carry_ff;
      status_in = status_ff;
      rpos_in   = rpos_ff;
      rval_in   = rval_ff;
      mem_wr    = '0;
      mem_raddr = k_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = ST_OK;
               rpos_in   = '0;
               rval_in   = '0;
               val_in    = req_word.item_value;
               state_in  = S_DONE;
               case (req_word.action)
                  ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT: begin
                     if (req_word.action == ACT_INS_AT && pos_x == '0) begin
                        status_in = ST_INVALID;
                     end else if (req_word.action == ACT_INS_AT &&
                                  pos_x > cnt_x + CMP_W'(1)) begin
                        status_in = ST_BEYOND;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        idx_in  = ins_idx;
                        rpos_in = POS_W'(CMP_W'(ins_idx) + CMP_W'(1));
                        if (CMP_W'(ins_idx) == cnt_x) begin
                           state_in = S_INS_PUT;
                        end else begin
                           // Shift the tail up one place, highest entry first.
                           mem_raddr = last_idx;
                           k_in      = last_idx;
                           state_in  = S_INS_SHIFT;
                        end
                     end
                  end
                  ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_AT, ACT_READ: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else if ((req_word.action == ACT_DEL_AT ||
                                   req_word.action == ACT_READ) && pos_x == '0) begin
                        status_in = ST_INVALID;
                     end else if ((req_word.action == ACT_DEL_AT ||
                                   req_word.action == ACT_READ) && pos_x > cnt_x) begin
                        status_in = ST_BEYOND;
                     end else begin
                        idx_in    = del_idx;
                        mem_raddr = del_idx;
                        rpos_in   = POS_W'(CMP_W'(del_idx) + CMP_W'(1));
                        state_in  = (req_word.action == ACT_READ) ? S_READ_WAIT
                                                                  : S_DEL_FIRST;
                     end
                  end
                  ACT_SEARCH: begin
                     if (empty) begin
                        status_in = ST_NOTFOUND;
                     end else begin
                        mem_raddr = '0;
                        k_in      = '0;
                        state_in  = S_SEARCH;
                     end
                  end
                  ACT_SORT: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else if (cnt_ff != CNT_W'(1)) begin
                        last_in   = last_idx;
                        mem_raddr = '0;
                        state_in  = S_SORT_LOAD;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_INS_SHIFT: begin
            mem_wr = '{en: 1'b1, addr: k_up, data: mem_rdata};
            if (k_ff == idx_ff) begin
               state_in = S_INS_PUT;
            end else begin
               mem_raddr = k_down;
               k_in      = k_down;
            end
         end
         S_INS_PUT: begin
            mem_wr   = '{en: 1'b1, addr: idx_ff, data: val_ff};
            cnt_in   = CNT_W'(cnt_ff + CNT_W'(1));
            state_in = S_DONE;
         end
         S_DEL_FIRST: begin
            rval_in = mem_rdata;
            if (idx_ff == last_idx) begin
               cnt_in   = CNT_W'(cnt_ff - CNT_W'(1));
               state_in = S_DONE;
            end else begin
               mem_raddr = ADDR_W'(idx_ff + ADDR_W'(1));
               k_in      = ADDR_W'(idx_ff + ADDR_W'(1));
               state_in  = S_DEL_SHIFT;
            end
         end
         S_DEL_SHIFT: begin
            mem_wr = '{en: 1'b1, addr: k_down, data: mem_rdata};
            if (k_ff == last_idx) begin
               cnt_in   = CNT_W'(cnt_ff - CNT_W'(1));
               state_in = S_DONE;
            end else begin
               mem_raddr = k_up;
               k_in      = k_up;
            end
         end
         S_READ_WAIT: begin
            rval_in  = mem_rdata;
            state_in = S_DONE;
         end
         S_SEARCH: begin
            if (mem_rdata == val_ff) begin
               rpos_in  = k_pos;
               state_in = S_DONE;
            end else if (k_ff == last_idx) begin
               status_in = ST_NOTFOUND;
               state_in  = S_DONE;
            end else begin
               mem_raddr = k_up;
               k_in      = k_up;
            end
         end
         S_SORT_LOAD: begin
            carry_in  = mem_rdata;
            mem_raddr = ADDR_W'(1);
            k_in      = ADDR_W'(1);
            state_in  = S_SORT_RUN;
         end
         S_SORT_RUN: begin
            // Bubble pass: keep the larger value moving up, drop the smaller one behind.
            if ($signed(carry_ff) > $signed(mem_rdata)) begin
               mem_wr = '{en: 1'b1, addr: k_down, data: mem_rdata};
            end else begin
               mem_wr   = '{en: 1'b1, addr: k_down, data: carry_ff};
               carry_in = mem_rdata;
            end
            if (k_ff == last_ff) begin
               state_in = S_SORT_TAIL;
            end else begin
               mem_raddr = k_up;
               k_in      = k_up;
            end
         end
         S_SORT_TAIL: begin
            mem_wr = '{en: 1'b1, addr: last_ff, data: carry_ff};
            if (last_ff == ADDR_W'(1)) begin
               state_in = S_DONE;
            end else begin
               last_in   = ADDR_W'(last_ff - ADDR_W'(1));
               mem_raddr = '0;
               state_in  = S_SORT_LOAD;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res_word = '{status: status_ff, result_position: rpos_ff,
                       result_value: rval_ff, list_length: POS_W'(cnt_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      k_ff      <= k_in;
      last_ff   <= last_in;
      carry_ff  <= carry_in;
      status_ff <= status_in;
      rpos_ff   <= rpos_in;
      rval_ff   <= rval_in;
   end

endmodule

// ===== hw/rtl/bounded_ordered_list_engine.sv =====
// Insert and delete shift each entry behind the given position one place at a time;
// search reads entries from the head until a hit, and sort runs bubble passes.
// One request is worked on at a time; the next word is taken in the cycle after the result
// moves to the output register, which holds it until the consumer takes it.
// Reset clears the length and control state; the entry memory is not cleared.
module bounded_ordered_list_engine import bole_pkg::*; (
   input logic        clock,
   input logic        reset,
   bole_req_if.sink   req_ch,
   bole_rsp_if.source rsp_ch
);

   bole_req_type      req_word;
   bole_res_type      res_word;
   logic              res_valid;
   logic              res_take;
   bole_wr_type       mem_wr;
   logic [ADDR_W-1:0] mem_raddr;
   logic [VAL_W-1:0]  mem_rdata;

   bole_res_type      out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   assign req_word = '{action: bole_action_type'(req_ch.action),
                       item_value: req_ch.item_value,
                       item_position: req_ch.item_position};

   bole_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_word  (req_word),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_word  (res_word),
      .mem_wr    (mem_wr),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   bole_ram #(
      .DATA_W (VAL_W),
      .WORDS  (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr.en),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // The output register takes a new word when it is empty or being drained.
   assign res_take = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (res_valid && res_take) begin
         out_in       = res_word;
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.status          = out_ff.status;
   assign rsp_ch.result_position = out_ff.result_position;
   assign rsp_ch.result_value    = out_ff.result_value;
   assign rsp_ch.list_length     = out_ff.list_length;

endmodule
